>>> rtl/kftl_pkg.sv
// Shared types, codes and defaults for the keyframe time lookup block.
`default_nettype none
package kftl_pkg;

  localparam int MAX_KEYS_DEF  = 64;
  localparam int TIME_BITS_DEF = 24;
  localparam int LEN_BITS      = 24;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 24'd65536;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FRAC_SET,
    S_DIV,
    S_INS_RD,
    S_INS_CHK,
    S_REM_RD,
    S_REM_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic  idle;
    logic  mod_init;
    logic  mod_step;
    logic  scan_rd;
    logic  scan_chk;
    logic  frac_init;
    logic  frac_step;
    logic  ins_init;
    logic  ins_rd;
    logic  ins_chk;
    logic  rem_init;
    logic  rem_rd;
    logic  rem_wr;
    logic  clr;
    logic  emit;
    logic  set_stat;
    stat_t stat;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    op_t  op;
    logic cnt_zero;
    logic full;
    logic idx_bad;
    logic mod_need;
    logic k_zero;
    logic scan_done;
    logic frac_skip;
    logic ptr_zero;
    logic key_gt;
    logic rem_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/kftl_if.sv
// Request, result and configuration channel interfaces.
`default_nettype none
interface kftl_req_if #(parameter int TIME_BITS = 24);
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [TIME_BITS-1:0] time_value;
  logic [5:0]           key_index;
  modport source (output valid, output operation, output time_value, output key_index,
                  input ready);
  modport sink (input valid, input operation, input time_value, input key_index,
                output ready);
endinterface

interface kftl_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  first_index;
  logic [5:0]  second_index;
  logic [16:0] fraction;
  logic [6:0]  key_count;
  modport source (output valid, output status, output first_index, output second_index,
                  output fraction, output key_count, input ready);
  modport sink (input valid, input status, input first_index, input second_index,
                input fraction, input key_count, output ready);
endinterface

interface kftl_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] animation_length;
  modport source (output valid, output animation_length, input ready);
  modport sink (input valid, input animation_length, output ready);
endinterface
`default_nettype wire

>>> rtl/kftl_ctrl.sv
// Controller state machine sequencing lookup, insert, remove and clear.
`default_nettype none
module kftl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  kftl_pkg::sts_t sts,
  output kftl_pkg::cmd_t cmd
);
  import kftl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sts.in_fire) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_LOOKUP: begin
            if (sts.cnt_zero) state_next = S_FINISH;
            else if (sts.mod_need) state_next = S_MOD;
            else state_next = S_SCAN_RD;
          end
          OP_INSERT: state_next = sts.full ? S_FINISH : S_INS_RD;
          OP_REMOVE: state_next = sts.idx_bad ? S_FINISH : S_REM_RD;
          default:   state_next = S_FINISH;
        endcase
      end
      S_MOD:      if (sts.k_zero) state_next = S_SCAN_RD;
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: state_next = sts.scan_done ? S_FRAC_SET : S_SCAN_RD;
      S_FRAC_SET: state_next = sts.frac_skip ? S_FINISH : S_DIV;
      S_DIV:      if (sts.k_zero) state_next = S_FINISH;
      S_INS_RD:   state_next = sts.ptr_zero ? S_FINISH : S_INS_CHK;
      S_INS_CHK:  state_next = sts.key_gt ? S_INS_RD : S_FINISH;
      S_REM_RD:   state_next = sts.rem_last ? S_FINISH : S_REM_WR;
      S_REM_WR:   state_next = S_REM_RD;
      S_FINISH:   if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.idle = 1'b1;
      S_DECODE: begin
        unique case (sts.op)
          OP_LOOKUP: begin
            if (sts.cnt_zero) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_EMPTY;
            end else if (sts.mod_need) begin
              cmd.mod_init = 1'b1;
            end
          end
          OP_INSERT: begin
            if (sts.full) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_FULL;
            end else begin
              cmd.ins_init = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (sts.idx_bad) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_BAD_INDEX;
            end else begin
              cmd.rem_init = 1'b1;
            end
          end
          default: cmd.clr = 1'b1;
        endcase
      end
      S_MOD:      cmd.mod_step  = 1'b1;
      S_SCAN_RD:  cmd.scan_rd   = 1'b1;
      S_SCAN_CHK: cmd.scan_chk  = 1'b1;
      S_FRAC_SET: cmd.frac_init = 1'b1;
      S_DIV:      cmd.frac_step = 1'b1;
      S_INS_RD:   cmd.ins_rd    = 1'b1;
      S_INS_CHK:  cmd.ins_chk   = 1'b1;
      S_REM_RD:   cmd.rem_rd    = 1'b1;
      S_REM_WR:   cmd.rem_wr    = 1'b1;
      S_FINISH:   cmd.emit      = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/kftl_dp.sv
// Datapath: key memory, count, wrap and fraction dividers, result register.
`default_nettype none
module kftl_dp #(
  parameter int MAX_KEYS  = kftl_pkg::MAX_KEYS_DEF,
  parameter int TIME_BITS = kftl_pkg::TIME_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  kftl_req_if.sink        request,
  kftl_res_if.source      result,
  kftl_cfg_if.sink        cfg,
  input  kftl_pkg::cmd_t  cmd,
  output kftl_pkg::sts_t  sts
);
  import kftl_pkg::*;

  localparam int AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW   = $clog2(MAX_KEYS + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam int TB   = TIME_BITS;
  localparam int W    = TB + 2;
  localparam int KW   = $clog2((TB > 17) ? TB : 17);

  logic [TB-1:0]       mem [MAX_KEYS];
  logic [TB-1:0]       rd_data;
  logic                we, re;
  logic [AW-1:0]       wa, ra;
  logic [TB-1:0]       wd;

  logic [LEN_BITS-1:0] cfg_len;
  logic [TB-1:0]       len_raw, len;
  op_t                 op_r;
  logic [TB-1:0]       t_r;
  logic [5:0]          idx_r;
  stat_t               st_r;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       ptr;
  logic [TB-1:0]       sh, prev, key0, t1;
  logic [TB:0]         t2;
  logic [W-1:0]        r, den;
  logic [16:0]         q;
  logic [KW-1:0]       k;
  logic [AW-1:0]       first, second;

  logic [W-1:0]        rs, rsub, rdiv;
  logic                dge;
  logic [CW:0]         ptr_inc;
  logic                load, ov;

  assign cfg.ready     = 1'b1;
  assign request.ready = cmd.idle;
  assign load          = request.valid & cmd.idle;

  assign len_raw = TB'(cfg_len);
  assign len     = (len_raw == '0) ? TB'(1) : len_raw;
  assign ptr_inc = {1'b0, ptr} + 1'b1;

  assign rs   = {r[W-2:0], sh[TB-1]};
  assign rsub = (rs >= W'(len)) ? rs - W'(len) : rs;
  assign dge  = (r >= den);
  assign rdiv = dge ? r - den : r;

  assign sts.in_fire   = load;
  assign sts.op        = op_r;
  assign sts.cnt_zero  = (cnt == '0);
  assign sts.full      = (cnt == CW'(MAX_KEYS));
  assign sts.idx_bad   = (CMPW'(idx_r) >= CMPW'(cnt));
  assign sts.mod_need  = (t_r > len);
  assign sts.k_zero    = (k == '0);
  assign sts.scan_done = (rd_data >= t_r) || (ptr_inc == {1'b0, cnt});
  assign sts.frac_skip = ((TB+1)'(t1) == t2) || (t_r <= t1);
  assign sts.ptr_zero  = (ptr == '0);
  assign sts.key_gt    = (rd_data > t_r);
  assign sts.rem_last  = (ptr_inc >= {1'b0, cnt});
  assign sts.out_free  = !ov || result.ready;

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = ptr[AW-1:0];
    ra = ptr[AW-1:0];
    wd = t_r;
    if (cmd.ins_rd) begin
      if (ptr == '0) begin
        we = 1'b1;
        wa = '0;
      end else begin
        re = 1'b1;
        ra = AW'(ptr - 1'b1);
      end
    end
    if (cmd.ins_chk) begin
      we = 1'b1;
      wd = (rd_data > t_r) ? rd_data : t_r;
    end
    if (cmd.scan_rd) re = 1'b1;
    if (cmd.rem_rd && !sts.rem_last) begin
      re = 1'b1;
      ra = AW'(ptr_inc);
    end
    if (cmd.rem_wr) begin
      we = 1'b1;
      wd = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= LEN_RESET;
    end else if (cfg.valid) begin
      cfg_len <= cfg.animation_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr) begin
      cnt <= '0;
    end else if ((cmd.ins_rd && ptr == '0) || (cmd.ins_chk && !(rd_data > t_r))) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.rem_rd && sts.rem_last) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r   <= op_t'(request.operation);
      t_r    <= request.time_value;
      idx_r  <= request.key_index;
      st_r   <= ST_OK;
      first  <= '0;
      second <= '0;
      q      <= '0;
    end
    if (cmd.set_stat) st_r <= cmd.stat;
    if (cmd.mod_init) begin
      sh <= t_r - 1'b1;
      r  <= '0;
      k  <= KW'(TB - 1);
    end
    if (cmd.mod_step) begin
      r  <= rsub;
      sh <= sh << 1;
      k  <= k - 1'b1;
      if (k == '0) t_r <= TB'(rsub) + 1'b1;
    end
    if (cmd.scan_chk) begin
      if (ptr == '0) key0 <= rd_data;
      if (rd_data >= t_r) begin
        second <= AW'(ptr);
        t2     <= (TB+1)'(rd_data);
        if (ptr != '0 && t_r < rd_data) begin
          first <= AW'(ptr - 1'b1);
          t1    <= prev;
        end else begin
          first <= AW'(ptr);
          t1    <= rd_data;
        end
      end else if (ptr_inc == {1'b0, cnt}) begin
        second <= '0;
        t2     <= (TB+1)'(len) + (TB+1)'((ptr == '0) ? rd_data : key0);
        first  <= AW'(ptr);
        t1     <= rd_data;
      end else begin
        prev <= rd_data;
        ptr  <= ptr + 1'b1;
      end
    end
    if (cmd.frac_init) begin
      r   <= W'(t_r) - W'(t1);
      den <= W'(t2) - W'(t1);
      q   <= '0;
      k   <= KW'(16);
    end
    if (cmd.frac_step) begin
      q <= {q[15:0], dge};
      r <= rdiv << 1;
      k <= k - 1'b1;
    end
    if (cmd.ins_init) ptr <= cnt;
    if (cmd.ins_chk && rd_data > t_r) ptr <= ptr - 1'b1;
    if (cmd.rem_init) ptr <= CW'(idx_r);
    if (cmd.rem_wr) ptr <= ptr + 1'b1;
    if (load && op_t'(request.operation) == OP_LOOKUP) ptr <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (cmd.emit) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status       <= st_r;
      result.first_index  <= 6'(first);
      result.second_index <= 6'(second);
      result.fraction     <= q;
      result.key_count    <= 7'(cnt);
    end
  end

  assign result.valid = ov;

endmodule
`default_nettype wire

>>> rtl/keyframe_time_lookup_core.sv
// Top level of the keyframe time lookup block.
// Keeps a sorted table of up to MAX_KEYS keyframe times in a memory with one read and one
// write port and answers one request word at a time: lookup, insert, remove by index,
// clear. Every request gives exactly one result word, held in an output register so the
// next request can be taken while it waits. Clear and refused requests go straight to
// the result. Insert moves the keys above the new time up one at a time; remove moves
// the keys after the index down one at a time; lookup reads keys in order until the
// search stops, then runs a bit-serial divider for the fraction unless it is zero by
// position, after a bit-serial wrap divider when the query time lies beyond the
// animation length. The memory's one read port makes the key moves and reads serial.
// The key store is not cleared after reset; only entries below the count are read.
`default_nettype none
module keyframe_time_lookup_core #(
  parameter int MAX_KEYS  = kftl_pkg::MAX_KEYS_DEF,
  parameter int TIME_BITS = kftl_pkg::TIME_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  kftl_req_if.sink   request,
  kftl_res_if.source result,
  kftl_cfg_if.sink   cfg
);
  import kftl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kftl_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  kftl_dp #(
    .MAX_KEYS  (MAX_KEYS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cfg     (cfg),
    .cmd     (cmd),
    .sts     (sts)
  );

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("request taken while a word is in progress");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.fraction <= 17'd65536))
    else $error("fraction above one");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_OK) |->
      (result.first_index == '0 && result.second_index == '0 && result.fraction == '0))
    else $error("error result carries lookup data");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (32'(result.key_count) <= 32'(MAX_KEYS)))
    else $error("key count above table size");

endmodule
`default_nettype wire

>>> verif/keyframe_time_lookup_core_checker.sv
// Checker that predicts and compares keyframe lookup result words.
`timescale 1ns / 1ps
module keyframe_time_lookup_core_checker
  import kftl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  kftl_req_if      request,
  kftl_res_if      result,
  kftl_cfg_if      cfg,
  output int       fail_count,
  output int       pending
);

  typedef struct packed {
    stat_t       status;
    logic [5:0]  first_index;
    logic [5:0]  second_index;
    logic [16:0] fraction;
    logic [6:0]  key_count;
  } outcome_t;

  logic [23:0] key_table [64];
  int          key_total;
  logic [23:0] anim_len;
  outcome_t    exp_buf [16];
  int          exp_wr, exp_rd;

  assign pending = exp_wr - exp_rd;

  function automatic logic [16:0] q16_ratio(logic [31:0] num, logic [31:0] den);
    logic [16:0] q;
    logic [33:0] r;
    q = '0;
    r = 34'(num);
    for (int k = 0; k < 17; k++) begin
      q = q << 1;
      if (r >= 34'(den)) begin
        r = r - 34'(den);
        q[0] = 1'b1;
      end
      r = r << 1;
    end
    return q;
  endfunction

  task automatic predict_word(op_t op, logic [23:0] tv, logic [5:0] idx);
    outcome_t    o;
    logic [31:0] len, t, t1, t2;
    int          i, f, pos;
    o = '0;
    o.status = ST_OK;
    case (op)
      OP_LOOKUP: begin
        if (key_total == 0) begin
          o.status = ST_EMPTY;
        end else begin
          len = 32'(anim_len);
          if (len == 0) len = 1;
          t = 32'(tv);
          if (t > len) t = ((t - 1) % len) + 1;
          i = 0;
          while (i < key_total && key_table[i] < t) i++;
          if (i == key_total) begin
            o.second_index = '0;
            t2 = len + 32'(key_table[0]);
            f = key_total - 1;
          end else begin
            o.second_index = i[5:0];
            t2 = 32'(key_table[i]);
            f = (i != 0 && t < key_table[i]) ? i - 1 : i;
          end
          o.first_index = f[5:0];
          t1 = 32'(key_table[f]);
          if (t1 == t2 || t <= t1) o.fraction = '0;
          else o.fraction = q16_ratio(t - t1, t2 - t1);
        end
      end
      OP_INSERT: begin
        if (key_total >= 64) begin
          o.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < key_total && key_table[pos] <= tv) pos++;
          for (int j = key_total; j > pos; j--) key_table[j] = key_table[j-1];
          key_table[pos] = tv;
          key_total++;
        end
      end
      OP_REMOVE: begin
        if (idx >= key_total) begin
          o.status = ST_BAD_INDEX;
        end else begin
          for (int j = idx; j + 1 < key_total; j++) key_table[j] = key_table[j+1];
          key_total--;
        end
      end
      default: key_total = 0;
    endcase
    o.key_count = key_total[6:0];
    exp_buf[exp_wr[3:0]] = o;
    exp_wr++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_total = 0;
      anim_len  = LEN_RESET;
      exp_wr    = 0;
      exp_rd    = 0;
      fail_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) anim_len = cfg.animation_length;
      if (request.valid && request.ready)
        predict_word(op_t'(request.operation), request.time_value, request.key_index);
      if (result.valid && result.ready) begin
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result word status=%0d", $time, result.status);
          fail_count <= fail_count + 1;
        end else begin
          outcome_t e, a;
          e = exp_buf[exp_rd[3:0]];
          exp_rd++;
          a = {stat_t'(result.status), result.first_index, result.second_index,
               result.fraction, result.key_count};
          if (a !== e) begin
            $display("%0t: mismatch expected st=%0d f=%0d s=%0d fr=%0d n=%0d",
                     $time, e.status, e.first_index, e.second_index, e.fraction,
                     e.key_count);
            $display("%0t:          actual   st=%0d f=%0d s=%0d fr=%0d n=%0d",
                     $time, a.status, a.first_index, a.second_index, a.fraction,
                     a.key_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/keyframe_time_lookup_core_test.sv
// Testbench top: stimulus, configuration phases and verdict for the lookup core.
`timescale 1ns / 1ps
module keyframe_time_lookup_core_test;
  import kftl_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending;
  int   idle_cycles;
  bit   hold_off;

  kftl_req_if #(.TIME_BITS(24)) request ();
  kftl_res_if result ();
  kftl_cfg_if cfg ();

  keyframe_time_lookup_core dut (.clk(clk), .rst(rst), .request(request),
                                 .result(result), .cfg(cfg));
  keyframe_time_lookup_core_checker chk (.clk(clk), .rst(rst), .request(request),
                                         .result(result), .cfg(cfg),
                                         .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  initial begin
    request.valid = 0; request.operation = 0; request.time_value = 0;
    request.key_index = 0; result.ready = 0; cfg.valid = 0;
    cfg.animation_length = 0;
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        result.ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        result.ready <= 0;
        repeat (w) @(posedge clk);
      end
      result.ready <= 1;
      @(posedge clk iff result.valid);
    end
  end

  task automatic send_word(op_t op, logic [23:0] tv, logic [5:0] idx);
    int w;
    w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (w > 0) begin
      request.valid <= 0;
      repeat (w) @(posedge clk);
    end
    request.valid <= 1;
    request.operation <= op;
    request.time_value <= tv;
    request.key_index <= idx;
    @(posedge clk iff request.ready);
  endtask

  task automatic set_length(logic [23:0] len);
    request.valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (60) @(posedge clk);
    cfg.valid <= 1;
    cfg.animation_length <= len;
    @(posedge clk iff cfg.ready);
    cfg.valid <= 0;
  endtask

  task automatic random_word(int fill_bias, logic [23:0] span);
    int r;
    r = $urandom_range(0, 99);
    if (r < fill_bias) send_word(OP_INSERT, 24'($urandom_range(0, span)), 6'($urandom));
    else if (r < 85) send_word(OP_LOOKUP,
                               ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                           : 24'($urandom_range(0, span)),
                               6'($urandom));
    else if (r < 98) send_word(OP_REMOVE, 24'($urandom), 6'($urandom_range(0, 70)));
    else send_word(OP_CLEAR, 24'($urandom), 6'($urandom));
  endtask

  initial begin
    logic [23:0] lens [6];
    lens = '{24'd1, 24'd0, 24'hFFFFFF, 24'd1000, 24'd37, 24'd65536};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send_word(OP_LOOKUP, 24'd5, 6'd0);
    send_word(OP_REMOVE, 24'd0, 6'd0);
    send_word(OP_INSERT, 24'd100, 6'h3f);
    send_word(OP_INSERT, 24'd100, 6'd0);
    send_word(OP_INSERT, 24'd0, 6'd0);
    send_word(OP_INSERT, 24'd60000, 6'd0);
    send_word(OP_LOOKUP, 24'd100, 6'd0);
    send_word(OP_LOOKUP, 24'd0, 6'd0);
    send_word(OP_LOOKUP, 24'd50, 6'd0);
    send_word(OP_LOOKUP, 24'd65000, 6'd0);
    send_word(OP_LOOKUP, 24'hFFFFFF, 6'd0);
    send_word(OP_LOOKUP, 24'd65536, 6'd0);
    send_word(OP_REMOVE, 24'hFFFFFF, 6'd4);
    send_word(OP_REMOVE, 24'd0, 6'd1);
    send_word(OP_CLEAR, 24'd0, 6'd0);
    for (int k = 0; k < 65; k++) send_word(OP_INSERT, 24'(k * 900), 6'd0);
    send_word(OP_LOOKUP, 24'd12345, 6'd0);
    send_word(OP_REMOVE, 24'd0, 6'd63);
    send_word(OP_CLEAR, 24'd0, 6'd0);
    // back pressure while the sender keeps going
    hold_off = 1;
    for (int k = 0; k < 30; k++) send_word(OP_INSERT, 24'($urandom_range(0, 65536)), 6'd0);
    // random phases over several lengths
    foreach (lens[p]) begin
      set_length(lens[p]);
      for (int k = 0; k < 280; k++)
        random_word((k % 100 < 50) ? 45 : 20, (lens[p] == 0) ? 24'd2 : lens[p] + 24'd2);
    end
    request.valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
